/* rtl/hprs_pkg.sv */
// Shared types, codes and character helpers for the HTTP response parser.
package hprs_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_STATUS  = 3'd1,
        PH_HEADERS = 3'd2,
        PH_BODY    = 3'd3,
        PH_DONE    = 3'd4,
        PH_ERROR   = 3'd5
    } phase_t;

    localparam logic [1:0] CMD_DATA  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BLANK      = 3'd1;
    localparam logic [2:0] ERR_NO_PROTO   = 3'd2;
    localparam logic [2:0] ERR_NO_DOT     = 3'd3;
    localparam logic [2:0] ERR_NO_STATUS  = 3'd4;
    localparam logic [2:0] ERR_NO_COLON   = 3'd5;
    localparam logic [2:0] ERR_CHUNK_LINE = 3'd6;
    localparam logic [2:0] ERR_CHUNK_BIG  = 3'd7;

    localparam logic [3:0] BD_SIZE     = 4'd0;
    localparam logic [3:0] BD_SIZE_DIG = 4'd1;
    localparam logic [3:0] BD_CHUNK    = 4'd2;
    localparam logic [3:0] BD_SKIP     = 4'd3;
    localparam logic [3:0] BD_FIXED    = 4'd4;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    function automatic logic [7:0] lower_of(input logic [7:0] c);
        lower_of = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == " ") || (c == 8'h09);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= "0") && (c <= "9");
    endfunction

    // bit 4 set when c is a hex digit, low nibble its value
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [7:0] l;
        begin
            l = lower_of(c);
            if (is_digit(c))
                hex_of = {1'b1, c[3:0]};
            else if (l >= "a" && l <= "f")
                hex_of = {1'b1, l[3:0] + 4'd9};
            else
                hex_of = 5'd0;
        end
    endfunction

    function automatic logic [15:0] dec16(input logic [15:0] acc, input logic [7:0] c);
        logic [19:0] t;
        begin
            t = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {16'd0, c[3:0]};
            dec16 = (t > 20'hFFFF) ? 16'hFFFF : t[15:0];
        end
    endfunction

    function automatic logic [7:0] proto_char(input logic [4:0] i);
        case (i)
            5'd0: proto_char = "h";
            5'd1: proto_char = "t";
            5'd2: proto_char = "t";
            5'd3: proto_char = "p";
            5'd4: proto_char = "/";
            default: proto_char = 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] cl_char(input logic [4:0] i);
        case (i)
            5'd0: cl_char = "c";
            5'd1: cl_char = "o";
            5'd2: cl_char = "n";
            5'd3: cl_char = "t";
            5'd4: cl_char = "e";
            5'd5: cl_char = "n";
            5'd6: cl_char = "t";
            5'd7: cl_char = "-";
            5'd8: cl_char = "l";
            5'd9: cl_char = "e";
            5'd10: cl_char = "n";
            5'd11: cl_char = "g";
            5'd12: cl_char = "t";
            5'd13: cl_char = "h";
            default: cl_char = 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] te_char(input logic [4:0] i);
        case (i)
            5'd0: te_char = "t";
            5'd1: te_char = "r";
            5'd2: te_char = "a";
            5'd3: te_char = "n";
            5'd4: te_char = "s";
            5'd5: te_char = "f";
            5'd6: te_char = "e";
            5'd7: te_char = "r";
            5'd8: te_char = "-";
            5'd9: te_char = "e";
            5'd10: te_char = "n";
            5'd11: te_char = "c";
            5'd12: te_char = "o";
            5'd13: te_char = "d";
            5'd14: te_char = "i";
            5'd15: te_char = "n";
            5'd16: te_char = "g";
            default: te_char = 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] enc_char(input logic [3:0] i);
        case (i)
            4'd0: enc_char = "c";
            4'd1: enc_char = "h";
            4'd2: enc_char = "u";
            4'd3: enc_char = "n";
            4'd4: enc_char = "k";
            4'd5: enc_char = "e";
            4'd6: enc_char = "d";
            default: enc_char = 8'd0;
        endcase
    endfunction

endpackage

/* rtl/http_response_stream_parser_unit.sv */
// Top level of the byte-wide HTTP response stream parser.
//
//  channel  dir  tdata                         tuser         tlast
//  s_axis   in   data_byte                     command       -
//  m_axis   out  status and flag fields        body_valid    body_last
//
// One beat per cycle when the receiver keeps up. Each accepted beat updates the parser state
// and loads the result register in the same cycle, so throughput is one byte per clock;
// the result beat is registered from the accepted input beat.
// rst_n clears the parser to idle and empties the result register.
// A stalled result holds; a new input beat is taken whenever the result
// register is empty or is being drained in the same cycle.
module http_response_stream_parser_unit
    import hprs_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // phase[2:0], body_byte[10:3], header_line_done[11], headers_done[12],
    // http_major[28:13], http_minor[44:29], status_code[60:45],
    // chunked_mode[61], message_done[62], error_code[65:63], zero[71:66]
    output logic [71:0] m_tdata,
    output logic        m_tuser,   // body_valid
    output logic        m_tlast    // body_last
);

    localparam int LB = LENGTH_BITS;

    phase_t        phase_reg, phase_next;
    logic [3:0]    sub_reg, sub_next;
    logic          pcr_reg, pcr_next;
    logic [4:0]    npos_reg, npos_next;
    logic [1:0]    flags_reg, flags_next;
    logic [3:0]    vms_reg, vms_next;
    logic [LB-1:0] len_reg, len_next;
    logic          have_len_reg, have_len_next;
    logic [LB-1:0] rem_reg, rem_next;
    logic [1:0]    skip_reg, skip_next;
    logic [LB-1:0] acc_reg, acc_next;
    logic [15:0]   major_reg, major_next;
    logic [15:0]   minor_reg, minor_next;
    logic [15:0]   status_reg, status_next;
    logic          chunked_reg, chunked_next;
    logic [2:0]    herr_reg, herr_next;

    logic          bv, bl, hl, hd, md;
    logic [7:0]    bb;
    logic          out_valid_reg;
    logic [71:0]   out_data_reg, out_data_next;
    logic          out_user_reg;
    logic          out_last_reg;
    logic          accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    hprs_step #(.LENGTH_BITS(LB)) u_step (
        .command(s_tuser), .data_byte(s_tdata),
        .phase_cur(phase_reg), .sub_cur(sub_reg), .pcr_cur(pcr_reg),
        .npos_cur(npos_reg), .flags_cur(flags_reg), .vms_cur(vms_reg),
        .len_cur(len_reg), .have_len_cur(have_len_reg), .rem_cur(rem_reg),
        .skip_cur(skip_reg), .acc_cur(acc_reg), .major_cur(major_reg),
        .minor_cur(minor_reg), .status_cur(status_reg),
        .chunked_cur(chunked_reg), .herr_cur(herr_reg),
        .phase_next(phase_next), .sub_next(sub_next), .pcr_next(pcr_next),
        .npos_next(npos_next), .flags_next(flags_next), .vms_next(vms_next),
        .len_next(len_next), .have_len_next(have_len_next), .rem_next(rem_next),
        .skip_next(skip_next), .acc_next(acc_next), .major_next(major_next),
        .minor_next(minor_next), .status_next(status_next),
        .chunked_next(chunked_next), .herr_next(herr_next),
        .body_valid(bv), .body_byte(bb), .body_last(bl),
        .header_line_done(hl), .headers_done(hd), .message_done(md)
    );

    always_comb
    begin
        out_data_next = '0;
        out_data_next[2:0]   = phase_next;
        out_data_next[10:3]  = bb;
        out_data_next[11]    = hl;
        out_data_next[12]    = hd;
        out_data_next[28:13] = major_next;
        out_data_next[44:29] = minor_next;
        out_data_next[60:45] = status_next;
        out_data_next[61]    = chunked_next;
        out_data_next[62]    = md;
        out_data_next[65:63] = (phase_next == PH_ERROR) ? herr_next : ERR_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_IDLE;
            sub_reg       <= 4'd0;
            pcr_reg       <= 1'b0;
            npos_reg      <= 5'd0;
            flags_reg     <= 2'b11;
            vms_reg       <= 4'd0;
            len_reg       <= '0;
            have_len_reg  <= 1'b0;
            rem_reg       <= '0;
            skip_reg      <= 2'd0;
            acc_reg       <= '0;
            major_reg     <= 16'd0;
            minor_reg     <= 16'd0;
            status_reg    <= 16'd0;
            chunked_reg   <= 1'b0;
            herr_reg      <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (accept) begin
                phase_reg     <= phase_next;
                sub_reg       <= sub_next;
                pcr_reg       <= pcr_next;
                npos_reg      <= npos_next;
                flags_reg     <= flags_next;
                vms_reg       <= vms_next;
                len_reg       <= len_next;
                have_len_reg  <= have_len_next;
                rem_reg       <= rem_next;
                skip_reg      <= skip_next;
                acc_reg       <= acc_next;
                major_reg     <= major_next;
                minor_reg     <= minor_next;
                status_reg    <= status_next;
                chunked_reg   <= chunked_next;
                herr_reg      <= herr_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept) begin
            out_data_reg <= out_data_next;
            out_user_reg <= bv;
            out_last_reg <= bl;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* rtl/hprs_step.sv */
// Next-state and result logic for one accepted beat of the response parser.
module hprs_step
    import hprs_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic [1:0]             command,
    input  logic [7:0]             data_byte,
    input  phase_t                 phase_cur,
    input  logic [3:0]             sub_cur,
    input  logic                   pcr_cur,
    input  logic [4:0]             npos_cur,
    input  logic [1:0]             flags_cur,
    input  logic [3:0]             vms_cur,
    input  logic [LENGTH_BITS-1:0] len_cur,
    input  logic                   have_len_cur,
    input  logic [LENGTH_BITS-1:0] rem_cur,
    input  logic [1:0]             skip_cur,
    input  logic [LENGTH_BITS-1:0] acc_cur,
    input  logic [15:0]            major_cur,
    input  logic [15:0]            minor_cur,
    input  logic [15:0]            status_cur,
    input  logic                   chunked_cur,
    input  logic [2:0]             herr_cur,
    output phase_t                 phase_next,
    output logic [3:0]             sub_next,
    output logic                   pcr_next,
    output logic [4:0]             npos_next,
    output logic [1:0]             flags_next,
    output logic [3:0]             vms_next,
    output logic [LENGTH_BITS-1:0] len_next,
    output logic                   have_len_next,
    output logic [LENGTH_BITS-1:0] rem_next,
    output logic [1:0]             skip_next,
    output logic [LENGTH_BITS-1:0] acc_next,
    output logic [15:0]            major_next,
    output logic [15:0]            minor_next,
    output logic [15:0]            status_next,
    output logic                   chunked_next,
    output logic [2:0]             herr_next,
    output logic                   body_valid,
    output logic [7:0]             body_byte,
    output logic                   body_last,
    output logic                   header_line_done,
    output logic                   headers_done,
    output logic                   message_done
);

    localparam int LB = LENGTH_BITS;
    localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};

    typedef struct packed {
        phase_t        phase;
        logic [3:0]    sub;
        logic          pcr;
        logic [4:0]    npos;
        logic [1:0]    flags;
        logic [3:0]    vms;
        logic [LB-1:0] len;
        logic          have_len;
        logic [LB-1:0] rem;
        logic [1:0]    skip;
        logic [LB-1:0] acc;
        logic [15:0]   major;
        logic [15:0]   minor;
        logic [15:0]   status;
        logic          chunked;
        logic [2:0]    herr;
        logic          o_valid;
        logic [7:0]    o_byte;
        logic          o_last;
        logic          o_hline;
        logic          o_hdone;
        logic          o_mdone;
    } st_t;

    function automatic logic [LB-1:0] dec_push(input logic [LB-1:0] acc, input logic [7:0] c);
        logic [LB+3:0] t;
        begin
            t = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{LB{1'b0}}, c[3:0]};
            dec_push = (t > {4'd0, LEN_MAX}) ? LEN_MAX : t[LB-1:0];
        end
    endfunction

    function automatic st_t fail(input st_t s, input logic [2:0] code);
        st_t r;
        begin
            r = s;
            r.phase = PH_ERROR;
            r.herr = code;
            r.pcr = 1'b0;
            fail = r;
        end
    endfunction

    function automatic st_t finish(input st_t s);
        st_t r;
        begin
            r = s;
            r.phase = PH_DONE;
            r.pcr = 1'b0;
            r.o_mdone = 1'b1;
            finish = r;
        end
    endfunction

    function automatic st_t status_char(input st_t s, input logic [7:0] c);
        st_t r;
        logic [3:0] ss;
        logic skip;
        begin
            r = s;
            ss = s.sub;
            skip = 1'b0;
            if (ss == 4'd0) begin
                if (is_blank(c))
                    skip = 1'b1;
                ss = 4'd1;
                r.npos = 5'd0;
            end
            if (skip) begin
                r = s;
            end
            else if (ss == 4'd1) begin
                if (r.npos >= 5'd5 || lower_of(c) != proto_char(r.npos)) begin
                    r = fail(r, ERR_NO_PROTO);
                end
                else begin
                    r.npos = r.npos + 5'd1;
                    r.sub = (r.npos == 5'd5) ? 4'd2 : 4'd1;
                end
            end
            else if (ss == 4'd2) begin
                if (is_digit(c))
                    r.major = dec16(r.major, c);
                else if (c == ".")
                    r.sub = 4'd3;
                else
                    r = fail(r, ERR_NO_DOT);
            end
            else if (ss == 4'd3) begin
                if (is_digit(c))
                    r.minor = dec16(r.minor, c);
                else
                    r.sub = is_blank(c) ? 4'd4 : 4'd6;
            end
            else if (ss == 4'd4) begin
                if (is_digit(c)) begin
                    r.status = dec16(r.status, c);
                    r.sub = 4'd5;
                end
                else if (!is_blank(c)) begin
                    r.sub = 4'd6;
                end
            end
            else if (ss == 4'd5) begin
                if (is_digit(c))
                    r.status = dec16(r.status, c);
                else
                    r.sub = 4'd6;
            end
            status_char = r;
        end
    endfunction

    function automatic st_t header_char(input st_t s, input logic [7:0] c);
        st_t r;
        logic go;
        begin
            r = s;
            go = 1'b1;
            if (s.sub <= 4'd1) begin
                go = 1'b0;
                if (c == CH_COLON) begin
                    if (s.npos != 5'd14) r.flags[0] = 1'b0;
                    if (s.npos != 5'd17) r.flags[1] = 1'b0;
                    r.sub = 4'd2;
                end
                else begin
                    if (s.npos >= 5'd14 || lower_of(c) != cl_char(s.npos)) r.flags[0] = 1'b0;
                    if (s.npos >= 5'd17 || lower_of(c) != te_char(s.npos)) r.flags[1] = 1'b0;
                    if (s.npos < 5'd31) r.npos = s.npos + 5'd1;
                    r.sub = 4'd1;
                end
            end
            else if (s.sub == 4'd2) begin
                if (is_blank(c))
                    go = 1'b0;
                else
                    r.sub = 4'd3;
            end
            if (go) begin
                if (r.vms < 4'd7 && c == enc_char(r.vms))
                    r.vms = r.vms + 4'd1;
                else
                    r.vms = 4'd15;
                if (r.sub == 4'd3) begin
                    if (is_digit(c))
                        r.acc = dec_push(r.acc, c);
                    else
                        r.sub = 4'd4;
                end
            end
            header_char = r;
        end
    endfunction

    function automatic st_t chunk_char(input st_t s, input logic [7:0] c);
        st_t r;
        logic [4:0] h;
        begin
            r = s;
            h = hex_of(c);
            if (!h[4])
                r = fail(r, ERR_CHUNK_LINE);
            else if (s.acc[LB-1:LB-4] != 4'd0)
                r = fail(r, ERR_CHUNK_BIG);
            else begin
                r.acc = {s.acc[LB-5:0], h[3:0]};
                r.sub = BD_SIZE_DIG;
            end
            chunk_char = r;
        end
    endfunction

    function automatic st_t line_content(input st_t s, input logic [7:0] c);
        if (s.phase == PH_STATUS)
            line_content = status_char(s, c);
        else if (s.phase == PH_HEADERS)
            line_content = header_char(s, c);
        else
            line_content = chunk_char(s, c);
    endfunction

    function automatic st_t clear_line(input st_t s);
        st_t r;
        begin
            r = s;
            r.sub = 4'd0;
            r.npos = 5'd0;
            r.flags = 2'b11;
            r.vms = 4'd0;
            r.acc = '0;
            clear_line = r;
        end
    endfunction

    function automatic st_t line_end(input st_t s);
        st_t r;
        begin
            r = s;
            if (s.phase == PH_STATUS) begin
                case (s.sub)
                    4'd0: r = fail(r, ERR_BLANK);
                    4'd1: r = fail(r, ERR_NO_PROTO);
                    4'd2: r = fail(r, ERR_NO_DOT);
                    4'd3, 4'd4: r = fail(r, ERR_NO_STATUS);
                    default:
                    begin
                        r = clear_line(r);
                        r.phase = PH_HEADERS;
                    end
                endcase
            end
            else if (s.phase == PH_HEADERS) begin
                if (s.sub == 4'd0) begin
                    // empty line: enter the body, or finish at once when there is no body
                    r.o_hdone = 1'b1;
                    r.phase = PH_BODY;
                    r.acc = '0;
                    if (s.chunked) begin
                        r.sub = BD_SIZE;
                    end
                    else if (s.have_len && s.len != '0) begin
                        r.rem = s.len;
                        r.sub = BD_FIXED;
                    end
                    else begin
                        r = finish(r);
                    end
                end
                else if (s.sub == 4'd1) begin
                    r = fail(r, ERR_NO_COLON);
                end
                else begin
                    if (s.flags[0]) begin
                        r.len = s.acc;
                        r.have_len = 1'b1;
                    end
                    else if (s.flags[1] && s.vms == 4'd7) begin
                        r.chunked = 1'b1;
                    end
                    r.o_hline = 1'b1;
                    r = clear_line(r);
                end
            end
            else begin
                if (s.sub != BD_SIZE_DIG) begin
                    r = fail(r, ERR_CHUNK_LINE);
                end
                else if (s.acc == '0) begin
                    r = finish(r);
                end
                else begin
                    r.rem = s.acc;
                    r.sub = BD_CHUNK;
                end
            end
            line_end = r;
        end
    endfunction

    st_t cur_s;
    st_t nxt_s;
    st_t tmp_s;

    always_comb
    begin
        cur_s = '0;
        cur_s.phase = phase_cur;
        cur_s.sub = sub_cur;
        cur_s.pcr = pcr_cur;
        cur_s.npos = npos_cur;
        cur_s.flags = flags_cur;
        cur_s.vms = vms_cur;
        cur_s.len = len_cur;
        cur_s.have_len = have_len_cur;
        cur_s.rem = rem_cur;
        cur_s.skip = skip_cur;
        cur_s.acc = acc_cur;
        cur_s.major = major_cur;
        cur_s.minor = minor_cur;
        cur_s.status = status_cur;
        cur_s.chunked = chunked_cur;
        cur_s.herr = herr_cur;
    end

    always_comb
    begin
        nxt_s = cur_s;
        tmp_s = cur_s;
        case (command)
            CMD_DATA:
            begin
                if (cur_s.phase == PH_IDLE || cur_s.phase == PH_DONE
                    || cur_s.phase == PH_ERROR) begin
                    nxt_s = cur_s;
                end
                else if (cur_s.phase == PH_BODY && cur_s.sub == BD_CHUNK) begin
                    nxt_s.o_valid = 1'b1;
                    nxt_s.o_byte = data_byte;
                    if (cur_s.rem[LB-1:1] == '0) begin
                        nxt_s.rem = '0;
                        nxt_s.o_last = 1'b1;
                        nxt_s.sub = BD_SKIP;
                        nxt_s.skip = 2'd2;
                    end
                    else begin
                        nxt_s.rem = cur_s.rem - 1'b1;
                    end
                end
                else if (cur_s.phase == PH_BODY && cur_s.sub == BD_SKIP) begin
                    if (cur_s.skip <= 2'd1) begin
                        nxt_s.skip = 2'd0;
                        nxt_s.sub = BD_SIZE;
                        nxt_s.acc = '0;
                    end
                    else begin
                        nxt_s.skip = cur_s.skip - 2'd1;
                    end
                end
                else if (cur_s.phase == PH_BODY && cur_s.sub == BD_FIXED) begin
                    nxt_s.o_valid = 1'b1;
                    nxt_s.o_byte = data_byte;
                    if (cur_s.rem[LB-1:1] == '0) begin
                        nxt_s.rem = '0;
                        nxt_s.o_last = 1'b1;
                        nxt_s = finish(nxt_s);
                    end
                    else begin
                        nxt_s.rem = cur_s.rem - 1'b1;
                    end
                end
                else begin
                    // a held CR is content unless LF follows
                    tmp_s.pcr = 1'b0;
                    if (cur_s.pcr && data_byte == CH_LF) begin
                        nxt_s = line_end(tmp_s);
                    end
                    else begin
                        if (cur_s.pcr)
                            tmp_s = line_content(tmp_s, CH_CR);
                        if (tmp_s.phase == PH_ERROR)
                            nxt_s = tmp_s;
                        else if (data_byte == CH_CR) begin
                            nxt_s = tmp_s;
                            nxt_s.pcr = 1'b1;
                        end
                        else
                            nxt_s = line_content(tmp_s, data_byte);
                    end
                end
            end
            CMD_START:
            begin
                nxt_s = '0;
                nxt_s.flags = 2'b11;
                nxt_s.phase = PH_STATUS;
            end
            CMD_CLOSE:
            begin
                if (cur_s.phase == PH_STATUS || cur_s.phase == PH_HEADERS
                    || cur_s.phase == PH_BODY)
                    nxt_s.phase = PH_DONE;
                nxt_s.pcr = 1'b0;
                nxt_s.o_mdone = 1'b1;
            end
            default:
            begin
                nxt_s = cur_s;
            end
        endcase
    end

    assign phase_next       = nxt_s.phase;
    assign sub_next         = nxt_s.sub;
    assign pcr_next         = nxt_s.pcr;
    assign npos_next        = nxt_s.npos;
    assign flags_next       = nxt_s.flags;
    assign vms_next         = nxt_s.vms;
    assign len_next         = nxt_s.len;
    assign have_len_next    = nxt_s.have_len;
    assign rem_next         = nxt_s.rem;
    assign skip_next        = nxt_s.skip;
    assign acc_next         = nxt_s.acc;
    assign major_next       = nxt_s.major;
    assign minor_next       = nxt_s.minor;
    assign status_next      = nxt_s.status;
    assign chunked_next     = nxt_s.chunked;
    assign herr_next        = nxt_s.herr;
    assign body_valid       = nxt_s.o_valid;
    assign body_byte        = nxt_s.o_byte;
    assign body_last        = nxt_s.o_last;
    assign header_line_done = nxt_s.o_hline;
    assign headers_done     = nxt_s.o_hdone;
    assign message_done     = nxt_s.o_mdone;

endmodule

/* verif/http_response_stream_parser_unit_tb.sv */
// Self-checking stream testbench for the HTTP response parser.
`timescale 1ns / 100ps

module http_response_stream_parser_unit_tb;
    import hprs_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    typedef struct packed {
        logic [2:0]  phase;
        logic        body_valid;
        logic [7:0]  body_byte;
        logic        body_last;
        logic        hline;
        logic        hdone;
        logic [15:0] major;
        logic [15:0] minor;
        logic [15:0] status;
        logic        chunked;
        logic        mdone;
        logic [2:0]  err;
    } parse_result_t;

    localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;
    // command code with no meaning, must leave the parser untouched
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // parser copy
    phase_t      ph;
    logic [3:0]  sub;
    logic        pcr;
    logic [4:0]  npos;
    logic [1:0]  nflags;
    logic [3:0]  vstate;
    logic [31:0] len_val;
    logic        have_len;
    logic [31:0] remain;
    logic [1:0]  skip;
    logic [31:0] acc;
    logic [15:0] vmaj, vmin, vstat;
    logic        chunked_f;
    logic [2:0]  err_held;
    parse_result_t cur;

    parse_result_t expected_results[$];
    int errors;
    int cycles;
    int hold_cycles;

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    http_response_stream_parser_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    function automatic logic [7:0] low_c(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic blank_c(input logic [7:0] c);
        return c == " " || c == 8'h09;
    endfunction

    function automatic logic digit_c(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [15:0] push16(input logic [15:0] a, input logic [7:0] c);
        logic [63:0] t;
        t = a * 64'd10 + (c - "0");
        return (t > 64'hFFFF) ? 16'hFFFF : t[15:0];
    endfunction

    function automatic logic [31:0] push32(input logic [31:0] a, input logic [7:0] c);
        logic [63:0] t;
        t = a * 64'd10 + (c - "0");
        return (t > {32'd0, LEN_MAX}) ? LEN_MAX : t[31:0];
    endfunction

    function automatic logic [7:0] word_at(input string w, input int i);
        return (i < w.len()) ? w[i] : 8'd0;
    endfunction

    task automatic clear_parser();
        sub = 0; pcr = 0; npos = 0; nflags = 2'b11; vstate = 0; len_val = 0;
        have_len = 0; remain = 0; skip = 0; acc = 0; vmaj = 0; vmin = 0; vstat = 0;
        chunked_f = 0; err_held = ERR_NONE;
    endtask

    task automatic go_error(input logic [2:0] code);
        ph = PH_ERROR; err_held = code; pcr = 0;
    endtask

    task automatic go_done();
        ph = PH_DONE; pcr = 0; cur.mdone = 1;
    endtask

    task automatic status_byte(input logic [7:0] c);
        logic [3:0] s;
        s = sub;
        if (s == 0)
        begin
            if (blank_c(c)) return;
            s = 1; npos = 0;
        end
        if (s == 1)
        begin
            if (npos >= 5 || low_c(c) != word_at("http/", npos))
            begin
                go_error(ERR_NO_PROTO);
                return;
            end
            npos++;
            sub = (npos == 5) ? 4'd2 : 4'd1;
        end
        else if (s == 2)
        begin
            if (digit_c(c)) vmaj = push16(vmaj, c);
            else if (c == ".") sub = 3;
            else go_error(ERR_NO_DOT);
        end
        else if (s == 3)
        begin
            if (digit_c(c)) vmin = push16(vmin, c);
            else sub = blank_c(c) ? 4'd4 : 4'd6;
        end
        else if (s == 4)
        begin
            if (blank_c(c)) return;
            if (digit_c(c))
            begin
                vstat = push16(vstat, c); sub = 5;
            end
            else sub = 6;
        end
        else if (s == 5)
        begin
            if (digit_c(c)) vstat = push16(vstat, c);
            else sub = 6;
        end
    endtask

    task automatic header_byte(input logic [7:0] c);
        if (sub <= 1)
        begin
            if (c == CH_COLON)
            begin
                if (npos != 14) nflags[0] = 0;
                if (npos != 17) nflags[1] = 0;
                sub = 2;
                return;
            end
            if (npos >= 14 || low_c(c) != word_at("content-length", npos)) nflags[0] = 0;
            if (npos >= 17 || low_c(c) != word_at("transfer-encoding", npos)) nflags[1] = 0;
            if (npos < 31) npos++;
            sub = 1;
            return;
        end
        if (sub == 2)
        begin
            if (blank_c(c)) return;
            sub = 3;
        end
        if (vstate < 7 && c == word_at("chunked", vstate)) vstate++;
        else vstate = 15;
        if (sub == 3)
        begin
            if (digit_c(c)) acc = push32(acc, c);
            else sub = 4;
        end
    endtask

    task automatic chunk_byte(input logic [7:0] c);
        logic [3:0] h;
        if (digit_c(c)) h = 4'(c - "0");
        else if (low_c(c) >= "a" && low_c(c) <= "f") h = 4'(low_c(c) - "a" + 8'd10);
        else
        begin
            go_error(ERR_CHUNK_LINE);
            return;
        end
        if (acc > (LEN_MAX >> 4))
        begin
            go_error(ERR_CHUNK_BIG);
            return;
        end
        acc = {acc[27:0], h};
        sub = BD_SIZE_DIG;
    endtask

    task automatic line_byte(input logic [7:0] c);
        if (ph == PH_STATUS) status_byte(c);
        else if (ph == PH_HEADERS) header_byte(c);
        else chunk_byte(c);
    endtask

    task automatic line_finish();
        if (ph == PH_STATUS)
        begin
            case (sub)
                0: go_error(ERR_BLANK);
                1: go_error(ERR_NO_PROTO);
                2: go_error(ERR_NO_DOT);
                3, 4: go_error(ERR_NO_STATUS);
                default:
                begin
                    ph = PH_HEADERS; sub = 0; npos = 0; nflags = 2'b11; vstate = 0; acc = 0;
                end
            endcase
        end
        else if (ph == PH_HEADERS)
        begin
            if (sub == 0)
            begin
                cur.hdone = 1;
                ph = PH_BODY; acc = 0;
                if (chunked_f) sub = BD_SIZE;
                else if (have_len && len_val != 0)
                begin
                    remain = len_val; sub = BD_FIXED;
                end
                else go_done();
            end
            else if (sub == 1) go_error(ERR_NO_COLON);
            else
            begin
                if (nflags[0])
                begin
                    len_val = acc; have_len = 1;
                end
                else if (nflags[1] && vstate == 7) chunked_f = 1;
                cur.hline = 1;
                sub = 0; npos = 0; nflags = 2'b11; vstate = 0; acc = 0;
            end
        end
        else
        begin
            if (sub != BD_SIZE_DIG) go_error(ERR_CHUNK_LINE);
            else if (acc == 0) go_done();
            else
            begin
                remain = acc; sub = BD_CHUNK;
            end
        end
    endtask

    task automatic data_in(input logic [7:0] c);
        if (ph == PH_IDLE || ph == PH_DONE || ph == PH_ERROR) return;
        if (ph == PH_BODY && (sub == BD_CHUNK || sub == BD_FIXED))
        begin
            cur.body_valid = 1; cur.body_byte = c;
            if (remain <= 1)
            begin
                remain = 0; cur.body_last = 1;
                if (sub == BD_FIXED) go_done();
                else
                begin
                    sub = BD_SKIP; skip = 2;
                end
            end
            else remain--;
            return;
        end
        if (ph == PH_BODY && sub == BD_SKIP)
        begin
            if (skip <= 1)
            begin
                skip = 0; sub = BD_SIZE; acc = 0;
            end
            else skip--;
            return;
        end
        if (pcr)
        begin
            pcr = 0;
            if (c == CH_LF)
            begin
                line_finish();
                return;
            end
            line_byte(CH_CR);
            if (ph == PH_ERROR) return;
        end
        if (c == CH_CR)
        begin
            pcr = 1;
            return;
        end
        line_byte(c);
    endtask

    task automatic predict_parse(input logic [1:0] cmd, input logic [7:0] c);
        cur = '0;
        if (cmd == CMD_DATA) data_in(c);
        else if (cmd == CMD_START)
        begin
            clear_parser(); ph = PH_STATUS;
        end
        else if (cmd == CMD_CLOSE)
        begin
            if (ph == PH_STATUS || ph == PH_HEADERS || ph == PH_BODY) ph = PH_DONE;
            pcr = 0; cur.mdone = 1;
        end
        cur.phase = ph; cur.major = vmaj; cur.minor = vmin; cur.status = vstat;
        cur.chunked = chunked_f;
        cur.err = (ph == PH_ERROR) ? err_held : ERR_NONE;
        expected_results.push_back(cur);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result checker
    always @(posedge clk)
    begin
        parse_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected beat", 32'd1, 32'd0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[2:0] != want.phase) report_mismatch("phase", m_tdata[2:0], want.phase);
                if (m_tuser != want.body_valid)
                    report_mismatch("body_valid", m_tuser, want.body_valid);
                if (m_tdata[10:3] != want.body_byte)
                    report_mismatch("body_byte", m_tdata[10:3], want.body_byte);
                if (m_tlast != want.body_last) report_mismatch("body_last", m_tlast, want.body_last);
                if (m_tdata[11] != want.hline) report_mismatch("header_line", m_tdata[11], want.hline);
                if (m_tdata[12] != want.hdone) report_mismatch("headers_done", m_tdata[12], want.hdone);
                if (m_tdata[28:13] != want.major) report_mismatch("major", m_tdata[28:13], want.major);
                if (m_tdata[44:29] != want.minor) report_mismatch("minor", m_tdata[44:29], want.minor);
                if (m_tdata[60:45] != want.status)
                    report_mismatch("status", m_tdata[60:45], want.status);
                if (m_tdata[61] != want.chunked) report_mismatch("chunked", m_tdata[61], want.chunked);
                if (m_tdata[62] != want.mdone) report_mismatch("msg_done", m_tdata[62], want.mdone);
                if (m_tdata[65:63] != want.err) report_mismatch("error", m_tdata[65:63], want.err);
                if (m_tdata[71:66] != 6'd0) report_mismatch("pad", m_tdata[71:66], 0);
            end
        end
    end

    // receiver stall, with an optional forced hold-off
    always @(posedge clk)
    begin
        if (!rst_n) m_tready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 2)
        begin
            // occasional long hold-off
            hold_cycles <= $urandom_range(10, 40);
            m_tready <= 1'b0;
        end
        else m_tready <= ($urandom_range(0, 99) < 75) || ($urandom_range(0, 99) < 50);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] c);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1; s_tuser <= cmd; s_tdata <= c;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_parse(cmd, c);
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) send_beat(CMD_DATA, t[i]);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_status_errors();
        send_beat(CMD_DATA, 8'hFF);           // ignored while idle
        send_beat(CMD_CLOSE, 8'h00);
        send_beat(CMD_START, 8'h00); send_text("\r\n");
        send_beat(CMD_START, 8'h00); send_text("HTXP");
        send_beat(CMD_START, 8'h00); send_text("http/1x");
        send_beat(CMD_START, 8'h00); send_text("HTTP/1.1\r\n");
        send_beat(CMD_START, 8'h00); send_beat(CMD_UNUSED, 8'h55);
        send_text("HTTP/99999.70000 99999 OK\r\nbad\r\n");
    endtask

    task automatic test_fixed_body();
        send_beat(CMD_START, 8'h00);
        send_text("HTTP/1.0 200 OK\r\nContent-Length: 3\r\nX: y\r\n\r\n");
        send_beat(CMD_DATA, 8'h00); send_beat(CMD_DATA, 8'hFF); send_beat(CMD_DATA, 8'h0D);
        send_beat(CMD_START, 8'h00);
        send_text("HTTP/1.1 204\r\ncontent-length: 0\r\n\r\n");
    endtask

    task automatic test_chunked();
        send_beat(CMD_START, 8'h00);
        send_text("HTTP/1.1 200 OK\r\nTransfer-Encoding:  chunked\r\n\r\n");
        send_text("2\r\nab\r\nA\r\n0123456789zz0\r\n");
        send_beat(CMD_START, 8'h00);
        send_text("HTTP/1.1 200\r\ntransfer-encoding: chunked\r\n\r\n123456789\r\n");
        send_beat(CMD_START, 8'h00);
        send_text("HTTP/1.1 200\r\ntransfer-encoding: chunked\r\n\r\n\r\n");
        send_beat(CMD_CLOSE, 8'h00);
    endtask

    task automatic test_random_messages();
        string names[5];
        int sent;
        int k;
        names = '{"Content-Length", "transfer-encoding", "CONTENT-LENGTH", "Host", "X-y"};
        sent = 0;
        while (sent < 480)
        begin
            k = $urandom_range(0, 9);
            send_beat(CMD_START, 8'h00);
            if (k == 0)
            begin
                // raw noise, all commands and bytes
                for (int i = 0; i < 12; i++)
                    send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                sent += 13;
                continue;
            end
            send_text($sformatf("HTTP/%0d.%0d %0d R\r\n", $urandom_range(0, 9),
                      $urandom_range(0, 9), $urandom_range(100, 599)));
            for (int h = $urandom_range(0, 2); h > 0; h--)
            begin
                k = $urandom_range(0, 4);
                if (k == 1)
                    send_text({names[k], ": ",
                               ($urandom_range(0, 3) == 0) ? string'("chunkd")
                                                           : string'("chunked"),
                               "\r\n"});
                else
                    send_text({names[k], ":", $sformatf("%0d", $urandom_range(0, 6)), "\r\n"});
                sent += 20;
            end
            send_text("\r\n");
            // body bytes, chunk lines and stray CR
            for (int i = $urandom_range(4, 20); i > 0; i--)
            begin
                k = $urandom_range(0, 7);
                if (k == 0) send_text("\r\n");
                else if (k == 1) send_text($sformatf("%0h\r\n", $urandom_range(0, 4)));
                else send_beat(CMD_DATA, 8'($urandom_range(0, 255)));
                sent++;
            end
            if ($urandom_range(0, 3) == 0) send_beat(CMD_CLOSE, 8'h00);
            sent += 20;
        end
    endtask

    task automatic test_backpressure();
        drain();
        hold_cycles = 200;
        send_beat(CMD_START, 8'h00);
        send_text("HTTP/1.1 200 OK\r\nContent-Length: 4\r\n\r\nwxyz");
        drain();
    endtask

    initial
    begin
        errors = 0; cycles = 0; hold_cycles = 0;
        ph = PH_IDLE; clear_parser();
        rst_n = 1'b0; s_tvalid = 1'b0; s_tdata = 8'd0; s_tuser = CMD_DATA;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_status_errors();
        test_fixed_body();
        test_chunked();
        test_backpressure();
        test_random_messages();
        drain();
        repeat (10) @(posedge clk);
        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
